FILE: rtl/core/irc_pkg.sv
// irc message classifier: shared constants, types and the in-token role function
`default_nettype none
package irc_pkg;

	// tokens begun per message at most
	localparam int TOKEN_LIMIT = 16;

	// parse phases
	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_TOKEN = 3'd1;
	localparam logic [2:0] PH_SEP   = 3'd2;
	localparam logic [2:0] PH_TRAIL = 3'd3;
	localparam logic [2:0] PH_IDLE  = 3'd4;

	// byte roles
	localparam logic [3:0] R_IGNORED = 4'd0;
	localparam logic [3:0] R_SEP     = 4'd1;
	localparam logic [3:0] R_DELIM   = 4'd2;
	localparam logic [3:0] R_NICK    = 4'd3;
	localparam logic [3:0] R_USER    = 4'd4;
	localparam logic [3:0] R_HOST    = 4'd5;
	localparam logic [3:0] R_CMD     = 4'd6;
	localparam logic [3:0] R_MIDDLE  = 4'd7;
	localparam logic [3:0] R_TMARK   = 4'd8;
	localparam logic [3:0] R_TTEXT   = 4'd9;

	// characters
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;

	typedef struct packed {
		logic [3:0] role;
		logic       bang;
		logic       at;
	} inner_t;

	// role of a byte inside a token that is neither the first byte of the message nor trailing text
	function automatic inner_t inner_role(input logic [4:0] idx, input logic [7:0] b,
			input logic prefix, input logic bang, input logic at);
		inner_t r;
		r.bang = bang;
		r.at   = at;
		if (idx == 5'd0 && prefix) begin
			if (!at && !bang && b == CH_BANG) begin
				r.bang = 1'b1;
				r.role = R_DELIM;
			end else if (!at && b == CH_AT) begin
				r.at   = 1'b1;
				r.role = R_DELIM;
			end else if (at) begin
				r.role = R_HOST;
			end else begin
				r.role = bang ? R_USER : R_NICK;
			end
		end else if (idx == (prefix ? 5'd1 : 5'd0)) begin
			r.role = R_CMD;
		end else begin
			r.role = R_MIDDLE;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/irc_message_field_classifier.sv
// irc message field classifier: per-byte role labelling with running message summary
`default_nettype none
// Takes one message byte per beat on the slave stream (tlast marks the final byte of a
// message) and returns one result beat per byte on the master stream. Each byte passes
// an input register, one level of classification logic against the parse state, and
// the result register. The block sustains one byte per cycle and stalls only when the
// result side does. The parse state is cleared after each byte with tlast set. Result
// tdata, from bit 0 up: byte_role[3:0], token_index[7:4], token_start[8],
// token_count[13:9], has_prefix[14], trailing_index[19:15] (two's complement, -1
// when none), malformed[20], zero pad to 24.
module irc_message_field_classifier (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // msg_byte[7:0]
	input  wire logic        s_tlast,   // last_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // byte_role, token_index, token_start, token_count,
	                                    // has_prefix, trailing_index, malformed, pad
	output logic             m_tlast    // message_done
);
	import irc_pkg::*;

	logic        in_valid_s1;
	logic [7:0]  in_byte_s1;
	logic        in_last_s1;
	logic        out_valid_s2;
	logic [23:0] out_data_s2;
	logic        out_last_s2;
	logic        adv;

	logic [2:0]        phase_q, phase_n;
	logic [4:0]        tokens_q, tokens_n;
	logic              prefix_q, prefix_n;
	logic              bang_q, bang_n;
	logic              at_q, at_n;
	logic signed [4:0] trail_q, trail_n;
	logic              bad_q, bad_n;

	logic [3:0] role;
	logic       start;
	logic [4:0] cur;
	inner_t     inr;
	logic [23:0] res;

	assign adv      = in_valid_s1 && (!out_valid_s2 || m_tready);
	assign s_tready = !in_valid_s1 || adv;
	assign m_tvalid = out_valid_s2;
	assign m_tdata  = out_data_s2;
	assign m_tlast  = out_last_s2;

	always_comb begin
		phase_n  = phase_q;
		tokens_n = tokens_q;
		prefix_n = prefix_q;
		bang_n   = bang_q;
		at_n     = at_q;
		trail_n  = trail_q;
		bad_n    = bad_q;
		role     = R_IGNORED;
		start    = 1'b0;
		inr      = '0;
		unique case (phase_q)
			PH_START: begin
				if (in_byte_s1 == CH_NUL || in_byte_s1 == CH_SPACE) begin
					bad_n   = 1'b1;
					phase_n = PH_IDLE;
				end else begin
					start    = 1'b1;
					tokens_n = tokens_q + 5'd1;
					phase_n  = PH_TOKEN;
					if (in_byte_s1 == CH_COLON) begin
						prefix_n = 1'b1;
						role     = R_DELIM;
					end else begin
						role = R_CMD;
					end
				end
			end
			PH_TOKEN: begin
				if (in_byte_s1 == CH_NUL) begin
					phase_n = PH_IDLE;
				end else if (in_byte_s1 == CH_SPACE) begin
					role    = R_SEP;
					phase_n = PH_SEP;
				end else begin
					inr    = inner_role(tokens_q - 5'd1, in_byte_s1, prefix_q, bang_q, at_q);
					role   = inr.role;
					bang_n = inr.bang;
					at_n   = inr.at;
				end
			end
			PH_SEP: begin
				if (in_byte_s1 == CH_SPACE) begin
					role = R_SEP;
				end else if (in_byte_s1 == CH_NUL || tokens_q >= 5'(TOKEN_LIMIT)) begin
					phase_n = PH_IDLE;
				end else begin
					// tokens_q is non-zero here, so this is never the first token
					start    = 1'b1;
					tokens_n = tokens_q + 5'd1;
					if (in_byte_s1 == CH_COLON) begin
						trail_n = tokens_q;
						phase_n = PH_TRAIL;
						role    = R_TMARK;
					end else begin
						phase_n = PH_TOKEN;
						inr     = inner_role(tokens_q, in_byte_s1, prefix_q, bang_q, at_q);
						role    = inr.role;
						bang_n  = inr.bang;
						at_n    = inr.at;
					end
				end
			end
			PH_TRAIL: begin
				if (in_byte_s1 == CH_NUL)
					phase_n = PH_IDLE;
				else
					role = R_TTEXT;
			end
			default: ;
		endcase
		cur = (tokens_n != 5'd0) ? tokens_n - 5'd1 : 5'd0;
		res = {3'b000, bad_n, trail_n, prefix_n, tokens_n, start, cur[3:0], role};
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_byte_s1 <= s_tdata;
			in_last_s1 <= s_tlast;
		end
	end

	// parse state, cleared after the final byte of a message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			tokens_q <= 5'd0;
			prefix_q <= 1'b0;
			bang_q   <= 1'b0;
			at_q     <= 1'b0;
			trail_q  <= -5'sd1;
			bad_q    <= 1'b0;
		end else if (adv) begin
			if (in_last_s1) begin
				phase_q  <= PH_START;
				tokens_q <= 5'd0;
				prefix_q <= 1'b0;
				bang_q   <= 1'b0;
				at_q     <= 1'b0;
				trail_q  <= -5'sd1;
				bad_q    <= 1'b0;
			end else begin
				phase_q  <= phase_n;
				tokens_q <= tokens_n;
				prefix_q <= prefix_n;
				bang_q   <= bang_n;
				at_q     <= at_n;
				trail_q  <= trail_n;
				bad_q    <= bad_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_s2 <= res;
			out_last_s2 <= in_last_s1;
		end
	end

	a_tokens_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		tokens_q <= 5'(TOKEN_LIMIT))
		else $error("token count beyond limit");

	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_START |-> (tokens_q == 5'd0 && !bad_q && !prefix_q && trail_q == -5'sd1))
		else $error("message start with stale state");

	a_start_role: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8] |-> (m_tdata[3:0] != R_IGNORED && m_tdata[3:0] != R_SEP))
		else $error("token start on a byte outside any token");

	a_malformed_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[20] |-> m_tdata[13:9] == 5'd0)
		else $error("malformed message with tokens");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_s2 && out_last_s2 == $past(in_last_s1))
		else $error("result beat lost or mislabelled");

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// testbench for irc_message_field_classifier: byte-role labelling checked against a local parser
`timescale 1ns / 100ps
module tb_top;
	import irc_pkg::*;

	localparam int RAND_BYTES  = 1150;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 8;

	// result tdata layout, msb first so role lands in bits 3:0
	typedef struct packed {
		logic [2:0] pad;
		logic       malformed;
		logic [4:0] trailing;
		logic       prefix;
		logic [4:0] count;
		logic       start;
		logic [3:0] index;
		logic [3:0] role;
	} label_t;

	typedef struct packed {
		label_t lab;
		logic   done;
	} result_t;

	typedef struct packed {
		logic [7:0] b;
		logic       eom;
		logic       typed;
		label_t     want;
	} row_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'd0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;

	irc_message_field_classifier u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// directed beats: {byte, tlast, typed,
	//   pad, malformed, trailing, prefix, count, start, index, role}
	row_t dir_rows [0:21] = '{
		{8'h20, 1'b0, 1'b1, 3'd0, 1'b1, 5'h1F, 1'b0, 5'd0, 1'b0, 4'd0, R_IGNORED},
		{8'hFF, 1'b1, 1'b1, 3'd0, 1'b1, 5'h1F, 1'b0, 5'd0, 1'b0, 4'd0, R_IGNORED},
		{8'h00, 1'b1, 1'b1, 3'd0, 1'b1, 5'h1F, 1'b0, 5'd0, 1'b0, 4'd0, R_IGNORED},
		{8'h3A, 1'b1, 1'b1, 3'd0, 1'b0, 5'h1F, 1'b1, 5'd1, 1'b1, 4'd0, R_DELIM},
		{8'h78, 1'b1, 1'b1, 3'd0, 1'b0, 5'h1F, 1'b0, 5'd1, 1'b1, 4'd0, R_CMD},
		{8'h3A, 1'b0, 1'b0, 24'd0},
		{8'h61, 1'b0, 1'b0, 24'd0},
		{8'h21, 1'b0, 1'b0, 24'd0},
		{8'h62, 1'b0, 1'b0, 24'd0},
		{8'h40, 1'b0, 1'b0, 24'd0},
		{8'h63, 1'b0, 1'b0, 24'd0},
		{8'h20, 1'b0, 1'b0, 24'd0},
		{8'h50, 1'b0, 1'b0, 24'd0},
		{8'h20, 1'b0, 1'b0, 24'd0},
		{8'h6D, 1'b0, 1'b0, 24'd0},
		{8'h20, 1'b0, 1'b0, 24'd0},
		{8'h3A, 1'b0, 1'b0, 24'd0},
		{8'h74, 1'b0, 1'b0, 24'd0},
		{8'h80, 1'b0, 1'b0, 24'd0},
		{8'h20, 1'b0, 1'b0, 24'd0},
		{8'h00, 1'b0, 1'b0, 24'd0},
		{8'hFF, 1'b1, 1'b0, 24'd0}
	};

	// parser state of the predictor
	logic [2:0] ph;
	logic [4:0] tok_n;
	logic       pfx_on;
	logic       bang_on;
	logic       at_on;
	logic [4:0] trail_tok;
	logic       bad_msg;

	result_t    label_q [$];
	logic [7:0] msg_bytes [$];
	int         mismatches  = 0;
	int         quiet_cycles = 0;
	int         idle_pct    = 0;
	int         stall_pct   = 0;
	result_t    got;
	result_t    want;

	function automatic void clear_parse();
		ph        = PH_START;
		tok_n     = 5'd0;
		pfx_on    = 1'b0;
		bang_on   = 1'b0;
		at_on     = 1'b0;
		trail_tok = 5'h1F;
		bad_msg   = 1'b0;
	endfunction

	// role of a byte inside a token, not the first byte of the message and not trailing text
	function automatic logic [3:0] word_role(input logic [4:0] tok, input logic [7:0] b);
		if (tok == 5'd0 && pfx_on) begin
			if (!at_on && !bang_on && b == CH_BANG) begin
				bang_on = 1'b1;
				return R_DELIM;
			end
			if (!at_on && b == CH_AT) begin
				at_on = 1'b1;
				return R_DELIM;
			end
			if (at_on)
				return R_HOST;
			return bang_on ? R_USER : R_NICK;
		end
		return (tok == {4'd0, pfx_on}) ? R_CMD : R_MIDDLE;
	endfunction

	function automatic logic [3:0] open_token(input logic [7:0] b);
		logic [4:0] idx;
		idx   = tok_n;
		tok_n = tok_n + 5'd1;
		if (idx == 5'd0) begin
			ph = PH_TOKEN;
			if (b == CH_COLON) begin
				pfx_on = 1'b1;
				return R_DELIM;
			end
			return R_CMD;
		end
		if (b == CH_COLON) begin
			trail_tok = idx;
			ph        = PH_TRAIL;
			return R_TMARK;
		end
		ph = PH_TOKEN;
		return word_role(idx, b);
	endfunction

	function automatic result_t label_byte(input logic [7:0] b, input logic eom);
		result_t    r;
		logic [3:0] role;
		logic       start;
		logic [4:0] cur;
		role  = R_IGNORED;
		start = 1'b0;
		case (ph)
		PH_START: begin
			if (b == CH_NUL || b == CH_SPACE) begin
				bad_msg = 1'b1;
				ph      = PH_IDLE;
			end else begin
				role  = open_token(b);
				start = 1'b1;
			end
		end
		PH_TOKEN: begin
			if (b == CH_NUL) begin
				ph = PH_IDLE;
			end else if (b == CH_SPACE) begin
				role = R_SEP;
				ph   = PH_SEP;
			end else begin
				role = word_role(tok_n - 5'd1, b);
			end
		end
		PH_SEP: begin
			if (b == CH_SPACE) begin
				role = R_SEP;
			end else if (b == CH_NUL || tok_n >= TOKEN_LIMIT) begin
				ph = PH_IDLE;
			end else begin
				role  = open_token(b);
				start = 1'b1;
			end
		end
		PH_TRAIL: begin
			if (b == CH_NUL)
				ph = PH_IDLE;
			else
				role = R_TTEXT;
		end
		default: ;
		endcase
		cur             = (tok_n != 5'd0) ? tok_n - 5'd1 : 5'd0;
		r.lab.pad       = 3'd0;
		r.lab.malformed = bad_msg;
		r.lab.trailing  = trail_tok;
		r.lab.prefix    = pfx_on;
		r.lab.count     = tok_n;
		r.lab.start     = start;
		r.lab.index     = cur[3:0];
		r.lab.role      = role;
		r.done          = eom;
		if (eom)
			clear_parse();
		return r;
	endfunction

	// token byte: anything but space and zero, with the delimiters weighted up
	function automatic void add_word(input int len);
		logic [7:0] c;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(9))
			0: c = CH_BANG;
			1: c = CH_AT;
			2: c = CH_COLON;
			default: begin
				c = 8'($urandom_range(255, 1));
				if (c == CH_SPACE)
					c = 8'h7E;
			end
			endcase
			msg_bytes.push_back(c);
		end
	endfunction

	function automatic void add_gap();
		int n;
		n = ($urandom_range(3) == 0) ? $urandom_range(3, 2) : 1;
		repeat (n) msg_bytes.push_back(CH_SPACE);
	endfunction

	function automatic void build_message();
		int kind;
		int n_mid;
		int n;
		msg_bytes.delete();
		kind = $urandom_range(99);
		if (kind < 8) begin
			n = $urandom_range(12, 1);
			repeat (n) msg_bytes.push_back(8'($urandom_range(255)));
		end else if (kind < 13) begin
			msg_bytes.push_back(CH_SPACE);
			add_word($urandom_range(4, 1));
		end else if (kind < 16) begin
			msg_bytes.push_back(CH_NUL);
			if ($urandom_range(1))
				add_word($urandom_range(3, 1));
		end else begin
			if ($urandom_range(1)) begin
				msg_bytes.push_back(CH_COLON);
				add_word($urandom_range(4, 1));
				if ($urandom_range(1)) begin
					msg_bytes.push_back(CH_BANG);
					add_word($urandom_range(4, 1));
				end
				if ($urandom_range(1)) begin
					msg_bytes.push_back(CH_AT);
					add_word($urandom_range(4, 1));
				end
				add_gap();
			end
			add_word($urandom_range(4, 1));
			// now and then enough parameters to run into the token limit
			n_mid = ($urandom_range(9) == 0) ? $urandom_range(20, 12) : $urandom_range(4);
			for (int i = 0; i < n_mid; i++) begin
				add_gap();
				add_word((n_mid > 8) ? 1 : $urandom_range(4, 1));
			end
			if ($urandom_range(1)) begin
				add_gap();
				msg_bytes.push_back(CH_COLON);
				n = $urandom_range(8);
				repeat (n) begin
					if ($urandom_range(4) == 0)
						msg_bytes.push_back(CH_SPACE);
					else
						msg_bytes.push_back(8'($urandom_range(255, 1)));
				end
			end
			if ($urandom_range(9) == 0)
				add_gap();
			if ($urandom_range(7) == 0) begin
				msg_bytes.push_back(CH_NUL);
				add_word($urandom_range(3, 1));
			end
		end
	endfunction

	// offer one beat, wait for it to be taken, then queue its expected labels
	task automatic feed(input logic [7:0] b, input logic eom, input logic typed,
			input label_t fixed);
		result_t r;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eom;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = label_byte(b, eom);
		if (typed) begin
			r.lab  = fixed;
			r.done = eom;
		end
		label_q.push_back(r);
	endtask

	task automatic flag(input string what, input int want_v, input int got_v);
		$display("%0t: %s expected %0d actual %0d", $time, what, want_v, got_v);
		mismatches++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (label_q.size() == 0) begin
					$display("%0t: unexpected result beat expected none actual %h",
						$time, m_tdata);
					mismatches++;
				end else begin
					want     = label_q.pop_front();
					got.lab  = m_tdata;
					got.done = m_tlast;
					if (got.lab.role !== want.lab.role)
						flag("byte_role", want.lab.role, got.lab.role);
					if (got.lab.index !== want.lab.index)
						flag("token_index", want.lab.index, got.lab.index);
					if (got.lab.start !== want.lab.start)
						flag("token_start", want.lab.start, got.lab.start);
					if (got.lab.count !== want.lab.count)
						flag("token_count", want.lab.count, got.lab.count);
					if (got.lab.prefix !== want.lab.prefix)
						flag("has_prefix", want.lab.prefix, got.lab.prefix);
					if (got.lab.trailing !== want.lab.trailing)
						flag("trailing_index", $signed(want.lab.trailing),
							$signed(got.lab.trailing));
					if (got.lab.malformed !== want.lab.malformed)
						flag("malformed", want.lab.malformed, got.lab.malformed);
					if (got.lab.pad !== want.lab.pad)
						flag("pad", want.lab.pad, got.lab.pad);
					if (got.done !== want.done)
						flag("message_done", want.done, got.done);
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles = quiet_cycles + 1;
		end
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int sent;
		clear_parse();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			feed(dir_rows[i].b, dir_rows[i].eom, dir_rows[i].typed, dir_rows[i].want);

		sent = 0;
		while (sent < RAND_BYTES) begin
			build_message();
			foreach (msg_bytes[i]) begin
				case (sent * 4 / RAND_BYTES)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 68;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 68;
				end
				default: begin
					idle_pct  = 36;
					stall_pct = 36;
				end
				endcase
				feed(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, '0);
				sent++;
			end
		end
		s_tvalid <= 1'b0;

		while (label_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && label_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/irc_pkg.sv
rtl/core/irc_message_field_classifier.sv
tb/tb_top.sv
